// ----- design/crfp_pkg.sv -----
// Shared types and constants for the response field parser.
// Used by crfp_digit and creg_response_field_parser; depends on nothing.
package crfp_pkg;

  localparam int LINE_POSITIONS = 256;

  localparam logic [7:0] CHAR_COLON = 8'd58;
  localparam logic [7:0] CHAR_COMMA = 8'd44;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;

  localparam logic [15:0] MAG_LIMIT = 16'd32768;

  // Number reader phases
  localparam logic [1:0] NUM_LEAD   = 2'd0;
  localparam logic [1:0] NUM_SIGN   = 2'd1;
  localparam logic [1:0] NUM_DIGITS = 2'd2;
  localparam logic [1:0] NUM_DONE   = 2'd3;

  typedef struct packed {
    logic        line_end;
    logic [7:0]  line_byte;
  } line_item_t;

  typedef struct packed {
    logic               result_code;
    logic signed [15:0] reg_status;
    logic               registered;
    logic               location_present;
    logic [7:0]         area_code_offset;
    logic [7:0]         cell_id_offset;
  } result_item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        negative;
    logic [15:0] magnitude;
  } num_state_t;

endpackage

// ----- design/crfp_digit.sv -----
// Signed decimal reader for one field: next-state logic for one byte.
// Depends on crfp_pkg.
module crfp_digit (
  input  logic                 enable,
  input  logic [7:0]           char_byte,
  input  crfp_pkg::num_state_t state,
  output crfp_pkg::num_state_t state_next
);

  logic        is_digit;
  logic        is_white;
  logic [3:0]  digit;
  logic [19:0] scaled;

  assign is_digit = (char_byte >= crfp_pkg::CHAR_ZERO) && (char_byte <= crfp_pkg::CHAR_NINE);
  assign is_white = ((char_byte >= crfp_pkg::CHAR_TAB) && (char_byte <= crfp_pkg::CHAR_CR))
                    || (char_byte == crfp_pkg::CHAR_SPACE);
  assign digit    = 4'(char_byte - crfp_pkg::CHAR_ZERO);
  // mag * 10 + d, by shifts
  assign scaled   = ({4'b0, state.magnitude} << 3) + ({4'b0, state.magnitude} << 1)
                    + 20'(digit);

  always_comb begin
    state_next = state;
    if (enable) begin
      case (state.phase)
        crfp_pkg::NUM_LEAD: begin
          if (is_white) begin
            state_next.phase = crfp_pkg::NUM_LEAD;
          end else if (char_byte == crfp_pkg::CHAR_PLUS) begin
            state_next.phase = crfp_pkg::NUM_SIGN;
          end else if (char_byte == crfp_pkg::CHAR_MINUS) begin
            state_next.negative = 1'b1;
            state_next.phase    = crfp_pkg::NUM_SIGN;
          end else if (is_digit) begin
            state_next.magnitude = 16'(digit);
            state_next.phase     = crfp_pkg::NUM_DIGITS;
          end else begin
            state_next.phase = crfp_pkg::NUM_DONE;
          end
        end
        crfp_pkg::NUM_SIGN: begin
          if (is_digit) begin
            state_next.magnitude = 16'(digit);
            state_next.phase     = crfp_pkg::NUM_DIGITS;
          end else begin
            state_next.phase = crfp_pkg::NUM_DONE;
          end
        end
        crfp_pkg::NUM_DIGITS: begin
          if (is_digit) begin
            // saturate at the largest negative magnitude, one past the largest positive
            state_next.magnitude = (scaled > 20'(crfp_pkg::MAG_LIMIT)) ?
                                   crfp_pkg::MAG_LIMIT : scaled[15:0];
          end else begin
            state_next.phase = crfp_pkg::NUM_DONE;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

endmodule

// ----- design/creg_response_field_parser.sv -----
// Registration report line parser: top level with handshakes and scan state.
// Depends on crfp_pkg and crfp_digit.
//
// Takes one line byte per transaction on the line channel and, on the byte marked
// line_end, delivers one result transaction. A byte is taken every cycle: bytes
// enter an input register, from which the field scan and both number readers
// update, and a line's result is registered into the output register as its
// last byte leaves the input register. The line channel stalls only while a
// last byte waits behind a result that the far side is still stalling.
module creg_response_field_parser #(
  parameter int LINE_POSITIONS = crfp_pkg::LINE_POSITIONS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   line_valid,
  output logic                   line_stall,
  input  crfp_pkg::line_item_t   line_item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output crfp_pkg::result_item_t result_item
);

  localparam int POS_W = $clog2(LINE_POSITIONS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_POSITIONS - 1);

  typedef enum logic [3:0] {
    WAIT_COLON,
    FIRST_START,
    FIRST_BODY,
    SECOND_START,
    SECOND_BODY,
    THIRD_START,
    THIRD_BODY,
    FOURTH_START,
    SCAN_DONE
  } scan_phase_t;

  // input register
  logic                 s1_valid;
  crfp_pkg::line_item_t s1_item;
  logic                 s1_advance;

  // scan state
  scan_phase_t          scan_phase, scan_phase_next;
  logic [POS_W-1:0]     byte_position;
  logic [2:0]           field_seen, field_seen_next;
  logic [7:0]           second_start, second_start_next;
  logic [7:0]           third_start, third_start_next;
  logic [7:0]           fourth_start, fourth_start_next;
  crfp_pkg::num_state_t first_num, first_num_next;
  crfp_pkg::num_state_t second_num, second_num_next;

  crfp_pkg::result_item_t result_next;
  crfp_pkg::num_state_t   status_src;
  logic [16:0]            neg_value;
  logic signed [15:0]     status_value;
  logic [7:0]             pos8;
  logic                   is_comma;
  logic                   non_space;

  assign s1_advance = s1_valid && !(s1_item.line_end && result_valid && result_stall);
  assign line_stall = s1_valid && !s1_advance;

  assign pos8      = 8'(byte_position);
  assign is_comma  = (s1_item.line_byte == crfp_pkg::CHAR_COMMA);
  assign non_space = (s1_item.line_byte != crfp_pkg::CHAR_SPACE);

  // Field scan; a start byte that is a comma also closes its field
  always_comb begin
    scan_phase_next   = scan_phase;
    field_seen_next   = field_seen;
    second_start_next = second_start;
    third_start_next  = third_start;
    fourth_start_next = fourth_start;
    unique case (scan_phase)
      WAIT_COLON: begin
        if (s1_item.line_byte == crfp_pkg::CHAR_COLON) begin
          scan_phase_next = FIRST_START;
        end
      end
      FIRST_START: begin
        if (non_space) begin
          field_seen_next = 3'd1;
          scan_phase_next = is_comma ? SECOND_START : FIRST_BODY;
        end
      end
      FIRST_BODY: begin
        if (is_comma) begin
          scan_phase_next = SECOND_START;
        end
      end
      SECOND_START: begin
        if (non_space) begin
          field_seen_next   = 3'd2;
          second_start_next = pos8;
          scan_phase_next   = is_comma ? THIRD_START : SECOND_BODY;
        end
      end
      SECOND_BODY: begin
        if (is_comma) begin
          scan_phase_next = THIRD_START;
        end
      end
      THIRD_START: begin
        if (non_space) begin
          field_seen_next  = 3'd3;
          third_start_next = pos8;
          scan_phase_next  = is_comma ? FOURTH_START : THIRD_BODY;
        end
      end
      THIRD_BODY: begin
        if (is_comma) begin
          scan_phase_next = FOURTH_START;
        end
      end
      FOURTH_START: begin
        if (non_space) begin
          field_seen_next   = 3'd4;
          fourth_start_next = pos8;
          scan_phase_next   = SCAN_DONE;
        end
      end
      SCAN_DONE: begin
        scan_phase_next = SCAN_DONE;
      end
      default: begin
        scan_phase_next = scan_phase;
      end
    endcase
  end

  crfp_digit u_first_digit (
    .enable     (field_seen_next >= 3'd1),
    .char_byte  (s1_item.line_byte),
    .state      (first_num),
    .state_next (first_num_next)
  );

  crfp_digit u_second_digit (
    .enable     (field_seen_next >= 3'd2),
    .char_byte  (s1_item.line_byte),
    .state      (second_num),
    .state_next (second_num_next)
  );

  // Result from the state as it stands after this byte
  always_comb begin
    status_src = ((field_seen_next == 3'd2) || (field_seen_next == 3'd4)) ?
                 second_num_next : first_num_next;
    neg_value  = 17'd0 - {1'b0, status_src.magnitude};
    if (status_src.negative) begin
      status_value = $signed(neg_value[15:0]);
    end else if (status_src.magnitude > 16'd32767) begin
      status_value = 16'sd32767;
    end else begin
      status_value = $signed(status_src.magnitude);
    end

    result_next                  = '0;
    if (field_seen_next == 3'd0) begin
      result_next.result_code = 1'b1;
      result_next.reg_status  = -16'sd1;
    end else begin
      result_next.reg_status = status_value;
      result_next.registered = (status_value == 16'sd1) || (status_value == 16'sd5);
      if (field_seen_next == 3'd3) begin
        result_next.location_present = 1'b1;
        result_next.area_code_offset = second_start_next;
        result_next.cell_id_offset   = third_start_next;
      end else if (field_seen_next == 3'd4) begin
        result_next.location_present = 1'b1;
        result_next.area_code_offset = third_start_next;
        result_next.cell_id_offset   = fourth_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      result_valid  <= 1'b0;
      scan_phase    <= WAIT_COLON;
      byte_position <= '0;
      field_seen    <= 3'd0;
      second_start  <= 8'd0;
      third_start   <= 8'd0;
      fourth_start  <= 8'd0;
      first_num     <= '0;
      second_num    <= '0;
    end else begin
      if (!line_stall) begin
        s1_valid <= line_valid;
        s1_item  <= line_item;
      end

      if (result_valid && !result_stall && !(s1_advance && s1_item.line_end)) begin
        result_valid <= 1'b0;
      end

      if (s1_advance) begin
        if (s1_item.line_end) begin
          // deliver and return to the start of a line
          result_valid  <= 1'b1;
          result_item   <= result_next;
          scan_phase    <= WAIT_COLON;
          byte_position <= '0;
          field_seen    <= 3'd0;
          second_start  <= 8'd0;
          third_start   <= 8'd0;
          fourth_start  <= 8'd0;
          first_num     <= '0;
          second_num    <= '0;
        end else begin
          scan_phase    <= scan_phase_next;
          field_seen    <= field_seen_next;
          second_start  <= second_start_next;
          third_start   <= third_start_next;
          fourth_start  <= fourth_start_next;
          first_num     <= first_num_next;
          second_num    <= second_num_next;
          if (byte_position != POS_LAST) begin
            byte_position <= byte_position + 1'b1;
          end
        end
      end
    end
  end

  a_no_field_early_phase: assert property (@(posedge clk) disable iff (rst)
    (field_seen == 3'd0) |-> (scan_phase == WAIT_COLON || scan_phase == FIRST_START))
    else $error("fields counted zero beyond first field start");

  a_second_reader_idle: assert property (@(posedge clk) disable iff (rst)
    (field_seen < 3'd2) |-> (second_num == '0))
    else $error("second number reader moved before second field");

  a_error_result_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_item.result_code) |->
      (result_item.reg_status == -16'sd1 && !result_item.registered &&
       !result_item.location_present))
    else $error("parse error result carries data");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    line_stall |-> (s1_valid && s1_item.line_end && result_valid && result_stall))
    else $error("line channel stalled without a blocked result");

endmodule
